// ===== hdl/crpt_pkg.sv =====
// Shared types, codes and character tables for the clock response parser.
// Used by crpt_parser, crpt_adjust and clock_response_parse_tz_adjust_core.
package crpt_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MARKER = 2'd1;
    localparam logic [1:0] STATUS_FORMAT    = 2'd2;
    localparam logic [1:0] STATUS_OLD       = 2'd3;

    localparam logic [1:0] REG_HOUR_OFFSET = 2'd0;
    localparam logic [1:0] REG_MIN_YEAR    = 2'd1;

    localparam logic [4:0]  HOUR_OFFSET_RESET = 5'd8;
    localparam logic [13:0] MIN_YEAR_RESET    = 14'd2023;
    localparam logic [13:0] ACC_MAX           = 14'd9999;
    localparam logic [6:0]  SMALL_MAX         = 7'd99;
    localparam logic [13:0] YEAR_BASE         = 14'd2000;
    localparam logic [13:0] YEAR_MAX          = 14'd9999;
    localparam logic [3:0]  FIELD_SECOND      = 4'd5;

    typedef enum logic [3:0] {
        PH_SEARCH   = 4'd0,
        PH_QUOTE    = 4'd1,
        PH_YEAR_WT  = 4'd2,
        PH_YEAR_DG  = 4'd3,
        PH_MON_WT   = 4'd4,
        PH_MON_DG   = 4'd5,
        PH_DAY_WT   = 4'd6,
        PH_DAY_DG   = 4'd7,
        PH_HOUR_WT  = 4'd8,
        PH_HOUR_DG  = 4'd9,
        PH_MIN_WT   = 4'd10,
        PH_MIN_DG   = 4'd11,
        PH_SEC_WT   = 4'd12,
        PH_SEC_DG   = 4'd13,
        PH_DONE     = 4'd14,
        PH_FAIL     = 4'd15
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_response;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [6:0]  out_minute;
        logic [6:0]  out_second;
    } out_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] year;
        logic [6:0]  cent;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } snap_t;

    function automatic logic [7:0] marker_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = "+";
            3'd1: c = "C";
            3'd2: c = "C";
            3'd3: c = "L";
            3'd4: c = "K";
            default: c = ":";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sep_char(input logic [3:0] field);
        logic [7:0] c;
        case (field)
            4'd0: c = "/";
            4'd1: c = "/";
            4'd2: c = ",";
            default: c = ":";
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
        logic [4:0] md;
        case (mo)
            4'd2: md = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: md = 5'd30;
            default: md = 5'd31;
        endcase
        return md;
    endfunction

    function automatic logic [6:0] small_sat(input logic [13:0] v);
        return (v > 14'(SMALL_MAX)) ? SMALL_MAX : v[6:0];
    endfunction

endpackage

// ===== hdl/clock_response_parse_tz_adjust_core.sv =====
// Top level of the clock response parser: configuration registers and the
// parser and adjust stages. Depends on crpt_pkg, crpt_parser, crpt_adjust.
//
// Usage:
//   s_valid/s_ready/s_data carry one response byte per transfer, with
//   end_of_response set on the last byte. Only that last byte yields a
//   result, on m_valid/m_ready/m_data: a status and the adjusted date-time.
//   One byte is taken per clock cycle while the result side flows.
//   The edge that transfers the last byte of a response loads the parser
//   snapshot; the checks and rollover then go from the snapshot into the
//   output register once that register is free to take them.
//   When m_ready is low the output register holds, the snapshot register
//   still takes one more finished response, and s_ready drops only when
//   both are full; bytes without the end flag also wait then.
//   cfg_wr_en with cfg_index 0 writes hour_offset, 1 writes min_year;
//   other indexes are dropped. Write only while no response is in flight.
//   Synchronous reset (aresetn low) returns to marker search, empties both
//   stages and loads hour_offset 8 and min_year 2023.
module clock_response_parse_tz_adjust_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  crpt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output crpt_pkg::out_t m_data,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [13:0]    cfg_data
);

    logic [4:0]      hour_offset_reg;
    logic [13:0]     min_year_reg;
    logic            snap_valid;
    logic            snap_ready;
    crpt_pkg::snap_t snap_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_offset_reg <= crpt_pkg::HOUR_OFFSET_RESET;
            min_year_reg    <= crpt_pkg::MIN_YEAR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                crpt_pkg::REG_HOUR_OFFSET: hour_offset_reg <= cfg_data[4:0];
                crpt_pkg::REG_MIN_YEAR:    min_year_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    crpt_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_data  (snap_data)
    );

    crpt_adjust u_adjust (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hour_offset (hour_offset_reg),
        .min_year    (min_year_reg),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap_data   (snap_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== hdl/crpt_parser.sv =====
// Byte parser: marker search, quote, six date-time numbers, snapshot on last byte.
// Depends on crpt_pkg.
module crpt_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  crpt_pkg::in_t s_data,
    output logic          snap_valid,
    input  logic          snap_ready,
    output crpt_pkg::snap_t snap_data
);

    crpt_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  match_reg, match_next;
    logic [13:0] acc_reg, acc_next;
    logic [13:0] year_reg;
    logic [6:0]  cent_reg;
    logic [6:0]  month_reg, day_reg, hour_reg, minute_reg;
    logic        snap_vld_reg;
    crpt_pkg::snap_t snap_reg, snap_next;

    logic [7:0]  rx;
    logic [3:0]  ph;
    logic [3:0]  field;
    logic        in_digits;
    logic        in_number;
    logic        is_ws, is_digit;
    logic [3:0]  digit;
    logic [16:0] acc_sum;
    logic [13:0] acc_sat;
    logic        store;
    logic [13:0] year_adj;
    logic [27:0] cent_prod;
    logic        take;

    assign rx        = s_data.rx_byte;
    assign ph        = phase_reg;
    assign field     = (ph - 4'd2) >> 1;
    assign in_digits = ph[0];
    assign in_number = (ph >= 4'(crpt_pkg::PH_YEAR_WT)) && (ph <= 4'(crpt_pkg::PH_SEC_DG));
    assign digit     = 4'(rx - "0");
    assign take      = s_valid && s_ready;

    always_comb begin
        is_ws    = rx inside {8'h20, [8'h09:8'h0D]};
        is_digit = rx inside {["0":"9"]};
    end

    assign acc_sum = in_digits ? (17'(acc_reg) * 17'd10 + 17'(digit)) : 17'(digit);
    assign acc_sat = (acc_sum > 17'(crpt_pkg::ACC_MAX)) ? crpt_pkg::ACC_MAX : acc_sum[13:0];

    assign store = in_number && in_digits && !is_digit && (field != crpt_pkg::FIELD_SECOND)
                   && (rx == crpt_pkg::sep_char(field));

    always_comb begin
        phase_next = phase_reg;
        match_next = match_reg;
        case (phase_reg)
            crpt_pkg::PH_SEARCH: begin
                if (match_reg < 3'd6 && rx == crpt_pkg::marker_char(match_reg)) begin
                    match_next = match_reg + 3'd1;
                    if (match_reg == 3'd5) begin
                        phase_next = crpt_pkg::PH_QUOTE;
                    end
                end else begin
                    match_next = (rx == "+") ? 3'd1 : 3'd0;
                end
            end
            crpt_pkg::PH_QUOTE: begin
                if (rx == 8'h22) begin
                    phase_next = crpt_pkg::PH_YEAR_WT;
                end else if (!is_ws) begin
                    phase_next = crpt_pkg::PH_FAIL;
                end
            end
            crpt_pkg::PH_DONE, crpt_pkg::PH_FAIL: begin
                phase_next = phase_reg;
            end
            default: begin
                if (is_digit) begin
                    phase_next = crpt_pkg::phase_t'({ph[3:1], 1'b1});
                end else if (!in_digits) begin
                    if (!is_ws) begin
                        phase_next = crpt_pkg::PH_FAIL;
                    end
                end else if (field == crpt_pkg::FIELD_SECOND) begin
                    phase_next = crpt_pkg::PH_DONE;
                end else if (store) begin
                    phase_next = crpt_pkg::phase_t'(ph + 4'd1);
                end else begin
                    phase_next = crpt_pkg::PH_FAIL;
                end
            end
        endcase
    end

    always_comb begin
        acc_next = acc_reg;
        if (in_number && is_digit) begin
            acc_next = acc_sat;
        end else if (store) begin
            acc_next = '0;
        end
        year_adj  = (acc_reg < crpt_pkg::YEAR_BASE) ? (acc_reg + crpt_pkg::YEAR_BASE) : acc_reg;
        cent_prod = 28'(year_adj) * 28'd5243;

        snap_next.year   = year_reg;
        snap_next.cent   = cent_reg;
        snap_next.month  = month_reg;
        snap_next.day    = day_reg;
        snap_next.hour   = hour_reg;
        snap_next.minute = minute_reg;
        snap_next.second = crpt_pkg::small_sat(acc_next);
        if (phase_next == crpt_pkg::PH_SEARCH) begin
            snap_next.status = crpt_pkg::STATUS_NO_MARKER;
        end else if (phase_next == crpt_pkg::PH_DONE || phase_next == crpt_pkg::PH_SEC_DG) begin
            snap_next.status = crpt_pkg::STATUS_OK;
        end else begin
            snap_next.status = crpt_pkg::STATUS_FORMAT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= crpt_pkg::PH_SEARCH;
            match_reg    <= '0;
            snap_vld_reg <= 1'b0;
        end else begin
            if (take) begin
                if (s_data.end_of_response) begin
                    phase_reg <= crpt_pkg::PH_SEARCH;
                    match_reg <= '0;
                end else begin
                    phase_reg <= phase_next;
                    match_reg <= match_next;
                end
            end
            if (take && s_data.end_of_response) begin
                snap_vld_reg <= 1'b1;
            end else if (snap_ready) begin
                snap_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            acc_reg <= acc_next;
            if (store) begin
                case (field)
                    4'd0: begin
                        year_reg <= year_adj;
                        cent_reg <= 7'(cent_prod >> 19);
                    end
                    4'd1: month_reg <= crpt_pkg::small_sat(acc_reg);
                    4'd2: day_reg   <= crpt_pkg::small_sat(acc_reg);
                    4'd3: hour_reg  <= crpt_pkg::small_sat(acc_reg);
                    default: minute_reg <= crpt_pkg::small_sat(acc_reg);
                endcase
            end
        end
        if (take && s_data.end_of_response) begin
            snap_reg <= snap_next;
        end
    end

    assign s_ready    = !snap_vld_reg || snap_ready;
    assign snap_valid = snap_vld_reg;
    assign snap_data  = snap_reg;

endmodule

// ===== hdl/crpt_adjust.sv =====
// Range and year checks, hour offset with day, month and year rollover.
// Holds the result register. Depends on crpt_pkg.
module crpt_adjust (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [4:0]      hour_offset,
    input  logic [13:0]     min_year,
    input  logic            snap_valid,
    output logic            snap_ready,
    input  crpt_pkg::snap_t snap_data,
    output logic            m_valid,
    input  logic            m_ready,
    output crpt_pkg::out_t  m_data
);

    logic           m_valid_reg;
    crpt_pkg::out_t m_data_reg, m_data_next;

    logic [1:0]  status;
    logic [5:0]  hsum;
    logic [1:0]  carry;
    logic [5:0]  hour_adj;
    logic [5:0]  day_adj;
    logic        hundred;
    logic        leap;
    logic [4:0]  md;
    logic        roll;
    logic [5:0]  day_fin;
    logic [3:0]  month_fin;
    logic [13:0] year_fin;

    always_comb begin
        if (snap_data.status != crpt_pkg::STATUS_OK) begin
            status = snap_data.status;
        end else if (snap_data.month < 7'd1 || snap_data.month > 7'd12 || snap_data.day < 7'd1
                     || snap_data.day > 7'd31 || snap_data.hour > 7'd23) begin
            status = crpt_pkg::STATUS_FORMAT;
        end else if (snap_data.year < min_year) begin
            status = crpt_pkg::STATUS_OLD;
        end else begin
            status = crpt_pkg::STATUS_OK;
        end
    end

    always_comb begin
        hsum = 6'(snap_data.hour[4:0]) + 6'(hour_offset);
        if (hsum >= 6'd48) begin
            carry    = 2'd2;
            hour_adj = hsum - 6'd48;
        end else if (hsum >= 6'd24) begin
            carry    = 2'd1;
            hour_adj = hsum - 6'd24;
        end else begin
            carry    = 2'd0;
            hour_adj = hsum;
        end
        day_adj = 6'(snap_data.day[4:0]) + 6'(carry);
        hundred = (snap_data.year == 14'(snap_data.cent) * 14'd100);
        leap    = hundred ? (snap_data.cent[1:0] == 2'd0) : (snap_data.year[1:0] == 2'd0);
        md      = crpt_pkg::month_days(snap_data.month[3:0], leap);
        roll    = day_adj > 6'(md);
        day_fin   = day_adj;
        month_fin = snap_data.month[3:0];
        year_fin  = snap_data.year;
        if (roll) begin
            day_fin = day_adj - 6'(md);
            if (snap_data.month[3:0] == 4'd12) begin
                month_fin = 4'd1;
                if (snap_data.year < crpt_pkg::YEAR_MAX) begin
                    year_fin = snap_data.year + 14'd1;
                end
            end else begin
                month_fin = snap_data.month[3:0] + 4'd1;
            end
        end
    end

    always_comb begin
        m_data_next = '0;
        m_data_next.status = status;
        if (status == crpt_pkg::STATUS_OK) begin
            m_data_next.out_year   = year_fin;
            m_data_next.out_month  = month_fin;
            m_data_next.out_day    = day_fin[4:0];
            m_data_next.out_hour   = hour_adj[4:0];
            m_data_next.out_minute = snap_data.minute;
            m_data_next.out_second = snap_data.second;
        end
    end

    assign snap_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            m_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
